[hdl/kch_pkg.sv]
// kch_pkg: shared types and constants for the k-mer count histogram
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kch_pkg;

    localparam int unsigned INDEX_WIDTH = 16;
    localparam int unsigned VALUE_WIDTH = 16;

    localparam logic [1:0] KIND_NUC   = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [7:0] CHAR_A_UP = 8'h41;
    localparam logic [7:0] CHAR_C_UP = 8'h43;
    localparam logic [7:0] CHAR_G_UP = 8'h47;
    localparam logic [7:0] CHAR_T_UP = 8'h54;
    localparam logic [7:0] CHAR_A_LO = 8'h61;
    localparam logic [7:0] CHAR_C_LO = 8'h63;
    localparam logic [7:0] CHAR_G_LO = 8'h67;
    localparam logic [7:0] CHAR_T_LO = 8'h74;

    localparam logic [1:0] SYM_A = 2'd0;
    localparam logic [1:0] SYM_C = 2'd1;
    localparam logic [1:0] SYM_G = 2'd2;
    localparam logic [1:0] SYM_T = 2'd3;

    localparam logic STATUS_ANSWER = 1'b0;
    localparam logic STATUS_ERROR  = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INC,
        OP_QUERY,
        OP_ERROR
    } kch_op_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             nucleotide_char;
        logic [INDEX_WIDTH-1:0] query_index;
    } kch_in_t;

    typedef struct packed {
        logic                   status;
        logic [VALUE_WIDTH-1:0] count;
    } kch_out_t;

    typedef struct packed {
        kch_op_t                op;
        logic [INDEX_WIDTH-1:0] addr;
    } kch_req_t;

    typedef struct packed {
        logic     valid;
        kch_out_t data;
    } kch_res_t;

endpackage

`default_nettype wire

[hdl/kmer_count_histogram.sv]
// kmer_count_histogram: top level, k-mer counter with query and output register
// depends on kch_pkg, kch_window, kch_table
//
// usage
//   in channel (in_valid/in_ready/in_data) carries one item: a nucleotide
//   character, an end of read or a count query. out channel
//   (out_valid/out_ready/out_data) carries query answers and error items for
//   invalid characters; characters and ends of read give no item.
//   after reset the counter memory is zeroed by a sweep of one entry per
//   cycle over its 4**K entries (65536 at K = 8); in_ready stays low until
//   it ends. throughput: one item per cycle while in_ready is high, set by
//   the single read port and single write port of the counter memory; an
//   increment reads at acceptance and writes back from the s1 stage register;
//   a repeated k-mer on consecutive items is served from the forwarding
//   register. a result passes the s1 stage register and the output register
//   before it is on out_data. when out_ready is low with a result held,
//   items still enter until a second result is made; it then holds the
//   pipeline and drops in_ready in the same cycle; nothing is lost or repeated.
//   reset (rst_n low, asynchronous) restarts the window and empties the
//   pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none

module kmer_count_histogram #(
    parameter int unsigned K           = 8,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire kch_pkg::kch_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output kch_pkg::kch_out_t      out_data
);
    import kch_pkg::*;

    kch_req_t req;
    kch_res_t res;
    logic     clear_done;
    logic     out_free;
    logic     advance;
    logic     fire;
    logic     out_valid_reg;
    kch_out_t out_data_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = !res.valid || out_free;
    assign in_ready = advance && clear_done;
    assign fire     = in_valid && in_ready;

    kch_window #(
        .K (K)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_data),
        .fire  (fire),
        .req   (req)
    );

    kch_table #(
        .K           (K),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .fire       (fire),
        .advance    (advance),
        .res        (res),
        .clear_done (clear_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            out_data_reg <= res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[hdl/kch_window.sv]
// kch_window: nucleotide decode and sliding k-mer window, builds table requests
// depends on kch_pkg
`timescale 1ns / 1ps
`default_nettype none

module kch_window #(
    parameter int unsigned K = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kch_pkg::kch_in_t item,
    input  wire logic             fire,
    output kch_pkg::kch_req_t     req
);
    import kch_pkg::*;

    localparam int unsigned KMER_BITS = 2 * K;
    localparam int unsigned SEEN_W    = $clog2(K + 1);

    logic [KMER_BITS-1:0] kmer_reg;
    logic [KMER_BITS-1:0] kmer_next;
    logic [SEEN_W-1:0]    seen_reg;
    logic [SEEN_W-1:0]    seen_next;
    logic [1:0]           sym;
    logic                 sym_ok;
    logic [KMER_BITS+1:0] shifted;
    logic [KMER_BITS-1:0] kmer_new;
    logic                 full;

    always_comb
    begin
        sym    = SYM_A;
        sym_ok = 1'b1;
        unique case (item.nucleotide_char) inside
            CHAR_A_UP, CHAR_A_LO: sym = SYM_A;
            CHAR_C_UP, CHAR_C_LO: sym = SYM_C;
            CHAR_G_UP, CHAR_G_LO: sym = SYM_G;
            CHAR_T_UP, CHAR_T_LO: sym = SYM_T;
            default:              sym_ok = 1'b0;
        endcase
    end

    assign shifted  = {kmer_reg, sym};
    assign kmer_new = shifted[KMER_BITS-1:0];
    assign full     = (seen_reg == SEEN_W'(K - 1));

    always_comb
    begin
        kmer_next = kmer_reg;
        seen_next = seen_reg;
        req.op    = OP_NONE;
        req.addr  = INDEX_WIDTH'(kmer_new);
        unique case (item.kind)
            KIND_NUC:
            begin
                if (!sym_ok)
                begin
                    req.op    = OP_ERROR;
                    kmer_next = '0;
                    seen_next = '0;
                end
                else
                begin
                    kmer_next = kmer_new;
                    if (full)
                    begin
                        req.op = OP_INC;
                    end
                    else
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
            end
            KIND_END:
            begin
                kmer_next = '0;
                seen_next = '0;
            end
            KIND_QUERY:
            begin
                req.op   = OP_QUERY;
                req.addr = item.query_index;
            end
            default:
            begin
                req.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_reg <= '0;
            seen_reg <= '0;
        end
        else if (fire)
        begin
            kmer_reg <= kmer_next;
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

[hdl/kch_table.sv]
// kch_table: counter memory with read-modify-write, write forwarding and clearing pass
// depends on kch_pkg
`timescale 1ns / 1ps
`default_nettype none

module kch_table #(
    parameter int unsigned K           = 8,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kch_pkg::kch_req_t req,
    input  wire logic              fire,
    input  wire logic              advance,
    output kch_pkg::kch_res_t      res,
    output logic                   clear_done
);
    import kch_pkg::*;

    localparam int unsigned KMER_BITS = 2 * K;
    localparam int unsigned DEPTH     = 1 << KMER_BITS;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];

    logic [KMER_BITS:0]     clear_cnt_reg;
    logic                   clearing;
    kch_op_t                s1_op_reg;
    logic [KMER_BITS-1:0]   s1_addr_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   last_valid_reg;
    logic [KMER_BITS-1:0]   last_addr_reg;
    logic [COUNT_WIDTH-1:0] last_data_reg;

    logic                   fwd_hit;
    logic [COUNT_WIDTH-1:0] cur;
    logic [31:0]            cur_ext;
    logic                   inc_wr;
    logic                   wr_en;
    logic [KMER_BITS-1:0]   wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [KMER_BITS-1:0]   rd_addr;

    assign clearing   = !clear_cnt_reg[KMER_BITS];
    assign clear_done = clear_cnt_reg[KMER_BITS];

    assign fwd_hit = last_valid_reg && (last_addr_reg == s1_addr_reg);
    assign cur     = fwd_hit ? last_data_reg : rd_data_reg;
    assign cur_ext = 32'(cur);
    assign inc_wr  = advance && (s1_op_reg == OP_INC);
    assign rd_addr = req.addr[KMER_BITS-1:0];

    always_comb
    begin
        if (clearing)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_cnt_reg[KMER_BITS-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en   = inc_wr;
            wr_addr = s1_addr_reg;
            wr_data = cur + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (fire)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg  <= '0;
            s1_op_reg      <= OP_NONE;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clear_cnt_reg  <= clear_cnt_reg + 1'b1;
                last_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                last_valid_reg <= inc_wr;
            end
            if (advance)
            begin
                s1_op_reg <= fire ? req.op : OP_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_addr_reg   <= rd_addr;
            last_addr_reg <= s1_addr_reg;
            last_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        res.valid       = 1'b0;
        res.data.status = STATUS_ANSWER;
        res.data.count  = '0;
        case (s1_op_reg)
            OP_QUERY:
            begin
                res.valid      = 1'b1;
                res.data.count = cur_ext[VALUE_WIDTH-1:0];
            end
            OP_ERROR:
            begin
                res.valid       = 1'b1;
                res.data.status = STATUS_ERROR;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
